// ----- hdl/kls_pkg.sv -----
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types and fixed widths of the k-th largest stream tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kls_pkg;

   // Fixed widths of the request, response and register fields.
   localparam int SAMPLE_W = 32;
   localparam int K_W      = 11;

   // Rank register value after reset.
   localparam logic [K_W-1:0] K_RESET = 11'd1;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_UP_RD   = 7'b0000010,
      ST_UP_CMP  = 7'b0000100,
      ST_DN_RD   = 7'b0001000,
      ST_DN_PICK = 7'b0010000,
      ST_DN_TEST = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } kls_state_type;

endpackage

`default_nettype wire

// ----- hdl/kls_req_if.sv -----
// ----------------------------------------------------------------------------
// kls_req_if
// Request channel: one signed stream value per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface kls_req_if;
   import kls_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/kls_rsp_if.sv -----
// ----------------------------------------------------------------------------
// kls_rsp_if
// Response channel: current k-th largest value and its qualifying flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface kls_rsp_if;
   import kls_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] kth_value;
   logic                       result_valid;

   modport source (output valid, output kth_value, output result_valid, input ready);
   modport sink   (input valid, input kth_value, input result_valid, output ready);
endinterface

`default_nettype wire

// ----- hdl/kls_ram.sv -----
// ----------------------------------------------------------------------------
// kls_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]  rd_data_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// ----- hdl/kth_largest_stream_tracker.sv -----
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker
// Keeps the k largest values of a stream in a min-heap and reports its root.
// ----------------------------------------------------------------------------
// Usage. Each request on req_if carries one signed sample. The block keeps the
// k largest samples seen so far in a binary min-heap held in a RAM of MAX_K
// entries, and answers every request with exactly one response on rsp_if: the
// heap root (the k-th largest value so far, or the smallest value held while
// the heap is still filling) and result_valid, which is set once k values
// have been seen. The user must write the rank k through csr_wr_en /
// csr_wr_data only while the block is idle; the block does not enforce this.
// Zero acts as one and values above MAX_K act as MAX_K.
// Timing. One request is worked on at a time and req_if.ready is low while it
// is. A single comparator, shared by all value tests, and the registered RAM
// read set the pace: a dropped sample goes from IDLE to FINISH, an insertion
// with sift-up alternates UP_RD and UP_CMP per parent compared, and a root
// replacement with sift-down steps through DN_RD, DN_PICK and DN_TEST per
// level descended, writing the value at a leaf or where it stops, then FINISH.
// Reset clears the fill count, sets k to 1 and empties the response register;
// the heap RAM is not cleared, as only entries already written are used.
// A stalled receiver holds the response register; the next request is still
// accepted and worked on, and only its completion waits for the slot to free.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_largest_stream_tracker #(
   parameter int MAX_K       = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   kls_req_if.sink                   req_if,
   kls_rsp_if.source                 rsp_if,
   input  wire logic                 csr_wr_en,
   input  wire logic [kls_pkg::K_W-1:0] csr_wr_data
);
   import kls_pkg::*;

   // Heap index, fill count and child index widths.
   localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CW = $clog2(MAX_K + 1);
   localparam int XW = AW + 2;
   localparam int VW = VALUE_WIDTH;

   // ---------------------------------------------------------------------
   // Rank register and effective rank
   // ---------------------------------------------------------------------
   logic [K_W-1:0] csr_k_ff;
   logic [CW-1:0]  k_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_k_ff <= K_RESET;
      end else if (csr_wr_en) begin
         csr_k_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (csr_k_ff == '0) begin
         k_eff = CW'(1);
      end else if (32'(csr_k_ff) > 32'(MAX_K)) begin
         k_eff = CW'(MAX_K);
      end else begin
         k_eff = CW'(csr_k_ff);
      end
   end

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   kls_state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] par_ff, par_in;
   logic [AW-1:0] chl_ff, chl_in;
   logic          second_ok_ff, second_ok_in;
   logic [VW-1:0] val_ff, val_in;
   logic [VW-1:0] pick_ff, pick_in;
   logic [AW-1:0] pick_idx_ff, pick_idx_in;
   logic [VW-1:0] root_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_kth_ff, rsp_kth_in;
   logic                rsp_flag_ff, rsp_flag_in;

   // RAM ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [VW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr_a, ram_raddr_b;
   logic [VW-1:0] ram_rdata_a, ram_rdata_b;

   kls_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_K)
   ) u_heap (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_data_a (ram_rdata_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_b (ram_rdata_b)
   );

   // ---------------------------------------------------------------------
   // The one shared comparator: signed cmp_a < cmp_b
   // ---------------------------------------------------------------------
   logic [VW-1:0] cmp_a, cmp_b;
   logic          cmp_lt;

   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   // Incoming sample at the heap's value width (zero-extended when wider).
   logic [63:0]   sample_wide;
   logic [VW-1:0] sample_v;
   logic [63:0]   root_wide;

   assign sample_wide = {32'b0, req_if.sample_value};
   assign sample_v    = sample_wide[VW-1:0];
   assign root_wide   = 64'(root_ff);

   // Fill count cut to the current rank, for when k was lowered.
   logic [CW-1:0] fill_cut;
   assign fill_cut = (fill_ff > k_eff) ? k_eff : fill_ff;

   // Child index in sift-down, one bit wider than any heap index doubled.
   logic [XW-1:0] child_x;
   logic [XW-1:0] child_x1;
   assign child_x  = (XW'(pos_ff) << 1) + XW'(1);
   assign child_x1 = child_x + XW'(1);

   logic req_fire;
   logic rsp_free;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      par_in       = par_ff;
      chl_in       = chl_ff;
      second_ok_in = second_ok_ff;
      val_in       = val_ff;
      pick_in      = pick_ff;
      pick_idx_in  = pick_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kth_in   = rsp_kth_ff;
      rsp_flag_in  = rsp_flag_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = val_ff;
      ram_raddr_a  = par_ff;
      ram_raddr_b  = par_ff;
      cmp_a        = root_ff;
      cmp_b        = sample_v;

      case (state_ff)
         ST_IDLE: begin
            // Root against the new sample decides a replacement.
            cmp_a = root_ff;
            cmp_b = sample_v;
            if (req_fire) begin
               val_in = sample_v;
               if (fill_cut < k_eff) begin
                  pos_in   = AW'(fill_cut);
                  fill_in  = fill_cut + CW'(1);
                  state_in = ST_UP_RD;
               end else if (cmp_lt) begin
                  pos_in   = '0;
                  fill_in  = fill_cut;
                  state_in = ST_DN_RD;
               end else begin
                  fill_in  = fill_cut;
                  state_in = ST_FINISH;
               end
            end
         end

         ST_UP_RD: begin
            if (pos_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
               ram_wdata = val_ff;
               state_in  = ST_FINISH;
            end else begin
               par_in      = (pos_ff - AW'(1)) >> 1;
               ram_raddr_a = (pos_ff - AW'(1)) >> 1;
               state_in    = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            // Move the parent down while it is greater than the new value.
            cmp_a = val_ff;
            cmp_b = ram_rdata_a;
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            if (cmp_lt) begin
               ram_wdata = ram_rdata_a;
               pos_in    = par_ff;
               state_in  = ST_UP_RD;
            end else begin
               ram_wdata = val_ff;
               state_in  = ST_FINISH;
            end
         end

         ST_DN_RD: begin
            if (child_x >= XW'(k_eff)) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = val_ff;
               state_in  = ST_FINISH;
            end else begin
               ram_raddr_a  = child_x[AW-1:0];
               ram_raddr_b  = child_x1[AW-1:0];
               chl_in       = child_x[AW-1:0];
               second_ok_in = child_x1 < XW'(k_eff);
               state_in     = ST_DN_PICK;
            end
         end

         ST_DN_PICK: begin
            // Smaller of the two children; the right one only if it exists.
            cmp_a = ram_rdata_b;
            cmp_b = ram_rdata_a;
            if (cmp_lt && second_ok_ff) begin
               pick_in     = ram_rdata_b;
               pick_idx_in = chl_ff + AW'(1);
            end else begin
               pick_in     = ram_rdata_a;
               pick_idx_in = chl_ff;
            end
            state_in = ST_DN_TEST;
         end

         ST_DN_TEST: begin
            cmp_a = pick_ff;
            cmp_b = val_ff;
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            if (cmp_lt) begin
               ram_wdata = pick_ff;
               pos_in    = pick_idx_ff;
               state_in  = ST_DN_RD;
            end else begin
               ram_wdata = val_ff;
               state_in  = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kth_in   = root_wide[SAMPLE_W-1:0];
               rsp_flag_in  = fill_ff >= k_eff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      par_ff       <= par_in;
      chl_ff       <= chl_in;
      second_ok_ff <= second_ok_in;
      val_ff       <= val_in;
      pick_ff      <= pick_in;
      pick_idx_ff  <= pick_idx_in;
      rsp_kth_ff   <= rsp_kth_in;
      rsp_flag_ff  <= rsp_flag_in;
      // The root is mirrored so the replacement test needs no RAM read.
      if (ram_we && ram_waddr == '0) begin
         root_ff <= ram_wdata;
      end
   end

   // No request is taken while reset is held.
   assign req_if.ready        = (state_ff == ST_IDLE) && !reset;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kth_value    = rsp_kth_ff;
   assign rsp_if.result_valid = rsp_flag_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_K))
      else $error("fill count exceeds heap depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("request accepted while a request is still in progress");

   a_flag_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.result_valid) |-> (fill_ff >= k_eff))
      else $error("full flag given while the heap is not full");

   a_sift_down_descends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_TEST && cmp_lt) |=> (pos_ff > $past(pos_ff)))
      else $error("sift-down did not move to a deeper entry");

endmodule

`default_nettype wire
